[design/ijh_pkg.sv]
// Shared types and constants for the interval jitter histogram.
package ijh_pkg;

    localparam int NUM_BINS_DEF = 2048;
    localparam int FIELD_W      = 32;
    localparam int IDX_W        = 11;
    localparam int MEAN_W       = 11;
    localparam int WIDE_W       = 64;

    typedef enum logic [1:0] {
        REQ_EVENT   = 2'd0,
        REQ_BIN     = 2'd1,
        REQ_SUMMARY = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_EV_RD,
        OP_EV_WR,
        OP_BIN_RD,
        OP_BIN_OUT,
        OP_P1_RD,
        OP_P1_MUL,
        OP_P1_ADD,
        OP_OV_RD,
        OP_OV_LATCH,
        OP_DIV1,
        OP_MEAN,
        OP_P2_RD,
        OP_P2_SQ,
        OP_P2_MUL,
        OP_P2_ADD,
        OP_DIV2,
        OP_SUM_OUT
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EV_RD,
        ST_EV_WR,
        ST_BIN_RD,
        ST_BIN_OUT,
        ST_P1_RD,
        ST_P1_MUL,
        ST_P1_ADD,
        ST_OV_RD,
        ST_OV_LATCH,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MEAN,
        ST_P2_RD,
        ST_P2_SQ,
        ST_P2_MUL,
        ST_P2_ADD,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_SUM_OUT
    } t_state;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
        logic empty;
        logic carry;
        logic div_done;
    } t_status;

endpackage

[design/interval_jitter_histogram.sv]
// Top level of the two-channel interval jitter histogram.
// After reset the block clears both bin memories, one bin a cycle, and holds
// busy high until the last bin is cleared. A transaction is taken when start
// is high and busy is low. An event does a bin read and write-back for both
// channels at once through each memory's port pair. A summary does a sum pass
// over the bins and, unless no samples were counted, a squared-deviation pass
// and two serial divisions.
// Each result appears for exactly one cycle with o_valid; it cannot be held off.
module interval_jitter_histogram #(
    parameter int NUM_BINS = ijh_pkg::NUM_BINS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [ijh_pkg::FIELD_W-1:0] i_event_time_us,
    input  logic [ijh_pkg::FIELD_W-1:0] i_sample_time,
    input  logic                        i_channel,
    input  logic [ijh_pkg::IDX_W-1:0]   i_bin_index,
    output logic                        o_valid,
    output logic [ijh_pkg::FIELD_W-1:0] o_bin_count,
    output logic [ijh_pkg::FIELD_W-1:0] o_over_count,
    output logic [ijh_pkg::FIELD_W-1:0] o_max_interval,
    output logic [ijh_pkg::MEAN_W-1:0]  o_mean_interval,
    output logic [ijh_pkg::WIDE_W-1:0]  o_dispersion,
    output logic [ijh_pkg::FIELD_W-1:0] o_total_count,
    output logic                        o_sum_overflowed,
    output logic                        o_no_samples
);
    import ijh_pkg::*;

    t_op     w_op;
    t_status w_status;

    ijh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_op       (w_op),
        .busy       (busy)
    );

    ijh_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .o_status         (w_status),
        .i_event_time_us  (i_event_time_us),
        .i_sample_time    (i_sample_time),
        .i_channel        (i_channel),
        .i_bin_index      (i_bin_index),
        .o_valid          (o_valid),
        .o_bin_count      (o_bin_count),
        .o_over_count     (o_over_count),
        .o_max_interval   (o_max_interval),
        .o_mean_interval  (o_mean_interval),
        .o_dispersion     (o_dispersion),
        .o_total_count    (o_total_count),
        .o_sum_overflowed (o_sum_overflowed),
        .o_no_samples     (o_no_samples)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result shown while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held longer than one cycle");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid) else $error("result right after accept");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_samples) |-> !o_sum_overflowed)
        else $error("empty summary flagged overflow");

endmodule

[design/ijh_div.sv]
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module ijh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ijh_pkg::WIDE_W-1:0] i_dividend,
    input  logic [ijh_pkg::WIDE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [ijh_pkg::WIDE_W-1:0] o_quotient
);
    import ijh_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W + 1);

    logic [WIDE_W:0]   r_rem;
    logic [WIDE_W-1:0] r_quo;
    logic [WIDE_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;
    logic [WIDE_W:0]   w_shift;
    logic [WIDE_W:0]   w_diff;

    assign w_shift = {r_rem[WIDE_W-1:0], r_quo[WIDE_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(WIDE_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            if (!w_diff[WIDE_W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[WIDE_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[design/ijh_datapath.sv]
// Bin memories, accumulators and result registers of the histogram.
module ijh_datapath #(
    parameter int NUM_BINS = ijh_pkg::NUM_BINS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ijh_pkg::t_op                i_op,
    output ijh_pkg::t_status            o_status,
    input  logic [ijh_pkg::FIELD_W-1:0] i_event_time_us,
    input  logic [ijh_pkg::FIELD_W-1:0] i_sample_time,
    input  logic                        i_channel,
    input  logic [ijh_pkg::IDX_W-1:0]   i_bin_index,
    output logic                        o_valid,
    output logic [ijh_pkg::FIELD_W-1:0] o_bin_count,
    output logic [ijh_pkg::FIELD_W-1:0] o_over_count,
    output logic [ijh_pkg::FIELD_W-1:0] o_max_interval,
    output logic [ijh_pkg::MEAN_W-1:0]  o_mean_interval,
    output logic [ijh_pkg::WIDE_W-1:0]  o_dispersion,
    output logic [ijh_pkg::FIELD_W-1:0] o_total_count,
    output logic                        o_sum_overflowed,
    output logic                        o_no_samples
);
    import ijh_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [FIELD_W-1:0] NB32 = FIELD_W'(NUM_BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);
    localparam logic [AW-1:0] WALK_END = AW'(NUM_BINS - 2);

    logic [FIELD_W-1:0] r_mem_ev [NUM_BINS];
    logic [FIELD_W-1:0] r_mem_sm [NUM_BINS];
    logic [FIELD_W-1:0] r_rd_ev, r_rd_sm;

    logic [FIELD_W-1:0] r_et, r_st, r_prev_et, r_prev_st, r_max_ev, r_max_sm;
    logic               r_ch;
    logic [IDX_W-1:0]   r_bidx;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_ev_addr, r_sm_addr;
    logic               r_ev_en, r_sm_en;
    logic [WIDE_W-1:0]  r_cnt, r_sum, r_prod, r_acc, r_t;
    logic [FIELD_W-1:0] r_over, r_c;
    logic [2*AW-1:0]    r_dd;
    logic [AW-1:0]      r_mean;
    logic               r_ovf;
    logic               r_valid_q;

    logic [FIELD_W-1:0] w_d_ev, w_d_sm, w_rd, w_idx32, w_mean32;
    logic               w_in_ev, w_in_sm, w_en_ev, w_en_sm;
    logic [AW-1:0]      w_a_ev, w_a_sm, w_rd_ev_a, w_rd_sm_a, w_ad;
    logic               w_we_ev, w_we_sm;
    logic [AW-1:0]      w_wa_ev, w_wa_sm;
    logic [FIELD_W-1:0] w_wd_ev, w_wd_sm;
    logic [WIDE_W:0]    w_acc_sum;
    logic               w_div_start, w_div_done;
    logic [WIDE_W-1:0]  w_dividend, w_quo;
    logic [AW+FIELD_W-1:0]   w_p1;
    logic [2*AW+FIELD_W-1:0] w_p2;

    assign w_d_ev  = r_et - r_prev_et;
    assign w_d_sm  = r_st - r_prev_st;
    assign w_in_ev = w_d_ev < NB32;
    assign w_in_sm = w_d_sm < NB32;
    assign w_en_ev = w_in_ev || (r_prev_et != '0);
    assign w_en_sm = w_in_sm || (r_prev_st != '0);
    assign w_a_ev  = w_in_ev ? w_d_ev[AW-1:0] : LAST_BIN;
    assign w_a_sm  = w_in_sm ? w_d_sm[AW-1:0] : LAST_BIN;
    assign w_idx32 = {{(FIELD_W-IDX_W){1'b0}}, r_bidx};
    assign w_rd    = r_ch ? r_rd_sm : r_rd_ev;
    assign w_ad    = (r_mean >= r_idx) ? (r_mean - r_idx) : (r_idx - r_mean);
    assign w_acc_sum = {1'b0, r_acc} + {1'b0, r_t};
    assign w_mean32  = {{(FIELD_W-AW){1'b0}}, r_mean};
    assign w_p1      = {{FIELD_W{1'b0}}, r_idx} * {{AW{1'b0}}, w_rd};
    assign w_p2      = {{FIELD_W{1'b0}}, r_dd} * {{(2*AW){1'b0}}, r_c};

    // Read address: event walks per channel, everything else shares one address
    always_comb begin
        w_rd_ev_a = r_idx;
        w_rd_sm_a = r_idx;
        case (i_op)
            OP_EV_RD: begin
                w_rd_ev_a = w_a_ev;
                w_rd_sm_a = w_a_sm;
            end
            OP_BIN_RD: begin
                w_rd_ev_a = w_idx32[AW-1:0];
                w_rd_sm_a = w_idx32[AW-1:0];
            end
            OP_OV_RD: begin
                w_rd_ev_a = LAST_BIN;
                w_rd_sm_a = LAST_BIN;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_we_ev = 1'b0;
        w_we_sm = 1'b0;
        w_wa_ev = r_idx;
        w_wa_sm = r_idx;
        w_wd_ev = '0;
        w_wd_sm = '0;
        case (i_op)
            OP_CLR: begin
                w_we_ev = 1'b1;
                w_we_sm = 1'b1;
            end
            OP_EV_WR: begin
                w_we_ev = r_ev_en;
                w_we_sm = r_sm_en;
                w_wa_ev = r_ev_addr;
                w_wa_sm = r_sm_addr;
                w_wd_ev = r_rd_ev + 1'b1;
                w_wd_sm = r_rd_sm + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_ev <= r_mem_ev[w_rd_ev_a];
        r_rd_sm <= r_mem_sm[w_rd_sm_a];
        if (w_we_ev) begin
            r_mem_ev[w_wa_ev] <= w_wd_ev;
        end
        if (w_we_sm) begin
            r_mem_sm[w_wa_sm] <= w_wd_sm;
        end
    end

    assign w_div_start = (i_op == OP_DIV1) || (i_op == OP_DIV2);
    assign w_dividend  = (i_op == OP_DIV1) ? r_sum : r_acc;

    ijh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_prev_et <= '0;
            r_prev_st <= '0;
            r_max_ev  <= '0;
            r_max_sm  <= '0;
            r_valid_q <= 1'b0;
        end else begin
            r_valid_q <= (i_op == OP_BIN_OUT) || (i_op == OP_SUM_OUT);
            case (i_op)
                OP_LOAD: r_idx <= '0;
                OP_CLR, OP_P1_ADD, OP_P2_ADD: r_idx <= r_idx + 1'b1;
                OP_MEAN: r_idx <= '0;
                OP_EV_RD: begin
                    r_prev_et <= r_et;
                    r_prev_st <= r_st;
                    if (!w_in_ev && r_prev_et != '0 && r_max_ev < w_d_ev) begin
                        r_max_ev <= w_d_ev;
                    end
                    if (!w_in_sm && r_prev_st != '0 && r_max_sm < w_d_sm) begin
                        r_max_sm <= w_d_sm;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_et   <= i_event_time_us;
                r_st   <= i_sample_time;
                r_ch   <= i_channel;
                r_bidx <= i_bin_index;
                r_cnt  <= '0;
                r_sum  <= '0;
                r_acc  <= '0;
                r_ovf  <= 1'b0;
            end
            OP_EV_RD: begin
                r_ev_addr <= w_a_ev;
                r_sm_addr <= w_a_sm;
                r_ev_en   <= w_en_ev;
                r_sm_en   <= w_en_sm;
            end
            OP_P1_MUL: begin
                r_prod <= WIDE_W'(w_p1);
                r_cnt  <= r_cnt + {{(WIDE_W-FIELD_W){1'b0}}, w_rd};
            end
            OP_P1_ADD: r_sum <= r_sum + r_prod;
            OP_OV_LATCH: r_over <= w_rd;
            OP_MEAN: r_mean <= w_quo[AW-1:0];
            OP_P2_SQ: begin
                r_dd <= {{AW{1'b0}}, w_ad} * {{AW{1'b0}}, w_ad};
                r_c  <= w_rd;
            end
            OP_P2_MUL: r_t <= WIDE_W'(w_p2);
            OP_P2_ADD: begin
                // Drop the sum and flag it once it wraps past 64 bits
                if (w_acc_sum[WIDE_W]) begin
                    r_acc <= '0;
                    r_ovf <= 1'b1;
                end else begin
                    r_acc <= w_acc_sum[WIDE_W-1:0];
                end
            end
            OP_BIN_OUT: begin
                o_bin_count      <= (w_idx32 < NB32) ? w_rd : '0;
                o_over_count     <= '0;
                o_max_interval   <= '0;
                o_mean_interval  <= '0;
                o_dispersion     <= '0;
                o_total_count    <= '0;
                o_sum_overflowed <= 1'b0;
                o_no_samples     <= 1'b0;
            end
            OP_SUM_OUT: begin
                o_bin_count    <= '0;
                o_over_count   <= r_over;
                o_max_interval <= r_ch ? r_max_sm : r_max_ev;
                if (r_cnt == '0) begin
                    o_mean_interval  <= '0;
                    o_dispersion     <= '0;
                    o_total_count    <= '0;
                    o_sum_overflowed <= 1'b0;
                    o_no_samples     <= 1'b1;
                end else begin
                    o_mean_interval  <= w_mean32[MEAN_W-1:0];
                    o_dispersion     <= w_quo;
                    o_total_count    <= (r_cnt[WIDE_W-1:FIELD_W] != '0) ? '1
                                                                      : r_cnt[FIELD_W-1:0];
                    o_sum_overflowed <= r_ovf;
                    o_no_samples     <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid            = r_valid_q;
    assign o_status.clr_last  = (r_idx == LAST_BIN);
    assign o_status.walk_last = (r_idx == WALK_END);
    assign o_status.empty     = (r_cnt == '0);
    assign o_status.carry     = w_acc_sum[WIDE_W];
    assign o_status.div_done  = w_div_done;

endmodule

[design/ijh_ctrl.sv]
// Sequencer for clear, event update, bin read and the two summary passes.
module ijh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_req_type,
    input  ijh_pkg::t_status      i_status,
    output ijh_pkg::t_op          o_op,
    output logic                  busy
);
    import ijh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_op = OP_CLR;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_op = OP_LOAD;
                    case (t_req'(i_req_type))
                        REQ_EVENT:   n_state = ST_EV_RD;
                        REQ_BIN:     n_state = ST_BIN_RD;
                        REQ_SUMMARY: n_state = ST_P1_RD;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EV_RD:   begin o_op = OP_EV_RD;   n_state = ST_EV_WR;   end
            ST_EV_WR:   begin o_op = OP_EV_WR;   n_state = ST_IDLE;    end
            ST_BIN_RD:  begin o_op = OP_BIN_RD;  n_state = ST_BIN_OUT; end
            ST_BIN_OUT: begin o_op = OP_BIN_OUT; n_state = ST_IDLE;    end
            ST_P1_RD:   begin o_op = OP_P1_RD;   n_state = ST_P1_MUL;  end
            ST_P1_MUL:  begin o_op = OP_P1_MUL;  n_state = ST_P1_ADD;  end
            ST_P1_ADD: begin
                o_op    = OP_P1_ADD;
                n_state = i_status.walk_last ? ST_OV_RD : ST_P1_RD;
            end
            ST_OV_RD:   begin o_op = OP_OV_RD;   n_state = ST_OV_LATCH; end
            ST_OV_LATCH: begin
                o_op    = OP_OV_LATCH;
                n_state = i_status.empty ? ST_SUM_OUT : ST_DIV1_GO;
            end
            ST_DIV1_GO: begin o_op = OP_DIV1; n_state = ST_DIV1_WAIT; end
            ST_DIV1_WAIT: begin
                if (i_status.div_done) n_state = ST_MEAN;
            end
            ST_MEAN:    begin o_op = OP_MEAN;    n_state = ST_P2_RD;  end
            ST_P2_RD:   begin o_op = OP_P2_RD;   n_state = ST_P2_SQ;  end
            ST_P2_SQ:   begin o_op = OP_P2_SQ;   n_state = ST_P2_MUL; end
            ST_P2_MUL:  begin o_op = OP_P2_MUL;  n_state = ST_P2_ADD; end
            ST_P2_ADD: begin
                o_op = OP_P2_ADD;
                // Stop the walk early on a wrapped sum
                if (i_status.carry || i_status.walk_last) begin
                    n_state = ST_DIV2_GO;
                end else begin
                    n_state = ST_P2_RD;
                end
            end
            ST_DIV2_GO: begin o_op = OP_DIV2; n_state = ST_DIV2_WAIT; end
            ST_DIV2_WAIT: begin
                if (i_status.div_done) n_state = ST_SUM_OUT;
            end
            ST_SUM_OUT: begin o_op = OP_SUM_OUT; n_state = ST_IDLE; end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule
